@@ rtl/utc_pkg.sv @@
// Shared types and constants of the UTF-8 to CJK table transcoder.
package utc_pkg;

	localparam logic [15:0] CP_REPLACE   = 16'h1FFF;
	localparam logic [15:0] SINGLE_LIMIT = 16'h0081;
	localparam logic [7:0]  ASCII_LIMIT  = 8'h80;
	localparam logic [7:0]  LEAD_MIN     = 8'hC2;
	localparam logic [7:0]  QMARK_BYTE   = 8'h3F;
	localparam logic [7:0]  FILL_BYTE    = 8'hA2;
	localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

	typedef struct packed {
		logic        command;
		logic [7:0]  data_byte;
		logic        end_of_string;
		logic [15:0] table_index;
		logic [15:0] table_entry;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        is_terminator;
		logic        stopped_early;
		logic [15:0] byte_count;
		logic        last;
	} out_item_t;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_BYTE,
		OP_LOOKUP,
		OP_TERM_ONLY
	} job_op_t;

	typedef struct packed {
		job_op_t     op;
		logic        term;
		logic        stop;
		logic [15:0] count;
		logic [15:0] addr;
		logic [15:0] wdata;
	} job_t;

endpackage

@@ rtl/utf8_to_cjk_table_transcoder_unit.sv @@
// Top level of the UTF-8 to CJK table transcoder.
//
// Channel   Direction  Handshake                 Payload
// input     in         push / full               in_item  (utc_pkg::in_item_t)
// result    out        empty / pop               out_item (utc_pkg::out_item_t)
//
// An item is taken in every cycle while the job queue has room; the front decoder is
// combinational logic and puts at most one job per item into the queue.
// The back part gives one result per cycle while the result queue has room: a table lookup
// yields two bytes, plus one more for a terminator, limited by the single result write per cycle.
// Reset clears all decoder and queue state; table entries are undefined until written.
// Either side may stall on its own; the two queues absorb the difference.
module utf8_to_cjk_table_transcoder_unit #(
	parameter int JOB_DEPTH = 4,
	parameter int RES_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  utc_pkg::in_item_t  in_item,
	output logic               empty,
	input  logic               pop,
	output utc_pkg::out_item_t out_item
);

	import utc_pkg::*;

	logic      job_full;
	logic      job_push;
	job_t      job_in;
	logic      job_empty;
	logic      job_pop;
	job_t      job_out;
	logic      res_full;
	logic      res_push;
	out_item_t res_in;

	utc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_item  (in_item),
		.job_full (job_full),
		.job_push (job_push),
		.job      (job_in)
	);

	utc_queue #(
		.WIDTH ($bits(job_t)),
		.DEPTH (JOB_DEPTH)
	) u_job_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wdata  (job_in),
		.full   (job_full),
		.pop    (job_pop),
		.rdata  (job_out),
		.empty  (job_empty)
	);

	utc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_empty (job_empty),
		.job       (job_out),
		.job_pop   (job_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	utc_queue #(
		.WIDTH ($bits(out_item_t)),
		.DEPTH (RES_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (out_item),
		.empty  (empty)
	);

endmodule

@@ rtl/utc_queue.sv @@
// Small first-in first-out queue held in flip-flops.
module utc_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = store_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wptr_q] <= wdata;
		end
	end

endmodule

@@ rtl/utc_front.sv @@
// Front part: accepts items, decodes UTF-8 and issues one job per item that needs work.
module utc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  utc_pkg::in_item_t in_item,
	input  logic             job_full,
	output logic             job_push,
	output utc_pkg::job_t    job
);

	import utc_pkg::*;

	logic [30:0] partial_q;
	logic [2:0]  rem_q;
	logic [7:0]  lead_q;
	logic        second_q;
	logic        halted_q;
	logic [15:0] count_q;

	logic [30:0] partial_n;
	logic [2:0]  rem_n;
	logic [7:0]  lead_n;
	logic        second_n;
	logic        complete;
	logic        invalid;
	logic        overlong;
	logic [30:0] cp;
	logic [7:0]  c;

	logic        accept;
	logic        is_data;
	logic        feed_en;
	logic        str_end;
	logic        emit;
	logic        single;
	logic [15:0] cp_sat;
	logic [1:0]  nbytes;
	logic [16:0] sum;
	logic [15:0] count_n;
	logic        halted_n;
	logic [2:0]  rem_after;

	assign c = in_item.data_byte;

	always_comb begin
		partial_n = partial_q;
		rem_n     = rem_q;
		lead_n    = lead_q;
		second_n  = second_q;
		complete  = 1'b0;
		invalid   = 1'b0;
		overlong  = 1'b0;
		cp        = '0;
		if (rem_q == 3'd0) begin
			lead_n   = c;
			second_n = 1'b1;
			if (c < ASCII_LIMIT) begin
				complete = 1'b1;
				cp       = {23'd0, c};
			end else if (c < LEAD_MIN) begin
				invalid = 1'b1;
			end else if (c < 8'hE0) begin
				partial_n = {26'd0, c[4:0]};
				rem_n     = 3'd1;
			end else if (c < 8'hF0) begin
				partial_n = {27'd0, c[3:0]};
				rem_n     = 3'd2;
			end else if (c < 8'hF8) begin
				partial_n = {28'd0, c[2:0]};
				rem_n     = 3'd3;
			end else if (c < 8'hFC) begin
				partial_n = {29'd0, c[1:0]};
				rem_n     = 3'd4;
			end else if (c < 8'hFE) begin
				partial_n = {30'd0, c[0]};
				rem_n     = 3'd5;
			end else begin
				invalid = 1'b1;
			end
		end else begin
			overlong = second_q && ((lead_q == 8'hE0 && c < 8'hA0) ||
				(lead_q == 8'hF0 && c < 8'h90) ||
				(lead_q == 8'hF8 && c < 8'h88) ||
				(lead_q == 8'hFC && c < 8'h84));
			if (c[7:6] != 2'b10 || overlong) begin
				invalid = 1'b1;
			end else begin
				second_n  = 1'b0;
				partial_n = {partial_q[24:0], c[5:0]};
				rem_n     = rem_q - 3'd1;
				if (rem_n == 3'd0) begin
					complete  = 1'b1;
					cp        = partial_n;
					partial_n = '0;
					second_n  = 1'b1;
				end
			end
		end
	end

	assign full      = job_full;
	assign accept    = push && !job_full;
	assign is_data   = !in_item.command;
	assign feed_en   = is_data && (c != 8'd0) && !halted_q;
	assign str_end   = is_data && ((c == 8'd0) || in_item.end_of_string);
	assign emit      = feed_en && complete;
	assign cp_sat    = (|cp[30:16]) ? CP_REPLACE : cp[15:0];
	assign single    = cp_sat < SINGLE_LIMIT;
	assign nbytes    = !emit ? 2'd0 : (single ? 2'd1 : 2'd2);
	assign sum       = {1'b0, count_q} + {15'd0, nbytes};
	assign count_n   = sum[16] ? COUNT_MAX : sum[15:0];
	assign halted_n  = halted_q || (feed_en && invalid);
	assign rem_after = feed_en ? rem_n : rem_q;

	always_comb begin
		job_push  = accept && (in_item.command || emit || str_end);
		job.term  = str_end;
		job.stop  = halted_n || (rem_after != 3'd0);
		job.count = count_n;
		job.wdata = in_item.table_entry;
		if (in_item.command) begin
			job.op   = OP_WRITE;
			job.addr = in_item.table_index;
		end else if (emit && single) begin
			job.op   = OP_BYTE;
			job.addr = {8'd0, cp_sat[7:0]};
		end else if (emit) begin
			job.op   = OP_LOOKUP;
			job.addr = cp_sat;
		end else begin
			job.op   = OP_TERM_ONLY;
			job.addr = cp_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			rem_q     <= '0;
			lead_q    <= '0;
			second_q  <= 1'b1;
			halted_q  <= 1'b0;
			count_q   <= '0;
		end else if (accept && is_data) begin
			if (str_end) begin
				partial_q <= '0;
				rem_q     <= '0;
				lead_q    <= '0;
				second_q  <= 1'b1;
				halted_q  <= 1'b0;
				count_q   <= '0;
			end else begin
				if (feed_en) begin
					partial_q <= partial_n;
					rem_q     <= rem_n;
					lead_q    <= lead_n;
					second_q  <= second_n;
				end
				halted_q <= halted_n;
				count_q  <= count_n;
			end
		end
	end

endmodule

@@ rtl/utc_back.sv @@
// Back part: holds the mapping table and turns each job into result items.
module utc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_empty,
	input  utc_pkg::job_t      job,
	output logic               job_pop,
	input  logic               res_full,
	output logic               res_push,
	output utc_pkg::out_item_t res
);

	import utc_pkg::*;

	logic [15:0] table_q [65536];
	logic        valid_s2;
	job_t        job_s2;
	logic [1:0]  idx_s2;
	logic [15:0] rd_s2;

	logic [1:0]  nbytes;
	logic [1:0]  nitems;
	logic        is_last;
	logic        done;
	logic        slot_free;
	logic        load;
	logic [7:0]  b0;
	logic [7:0]  b1;

	always_comb begin
		case (job_s2.op)
			OP_BYTE:   nbytes = 2'd1;
			OP_LOOKUP: nbytes = 2'd2;
			default:   nbytes = 2'd0;
		endcase
	end

	assign nitems  = nbytes + {1'b0, job_s2.term};
	assign is_last = (idx_s2 == nitems - 2'd1);
	assign b0      = (rd_s2 == {8'd0, QMARK_BYTE}) ? FILL_BYTE : rd_s2[7:0];
	assign b1      = (rd_s2 == {8'd0, QMARK_BYTE}) ? FILL_BYTE : rd_s2[15:8];

	always_comb begin
		res.last = is_last;
		if (idx_s2 < nbytes) begin
			res.is_terminator = 1'b0;
			res.stopped_early = 1'b0;
			res.byte_count    = '0;
			if (job_s2.op == OP_BYTE) begin
				res.out_byte = job_s2.addr[7:0];
			end else begin
				res.out_byte = (idx_s2 == 2'd0) ? b0 : b1;
			end
		end else begin
			res.out_byte      = '0;
			res.is_terminator = 1'b1;
			res.stopped_early = job_s2.stop;
			res.byte_count    = job_s2.count;
		end
	end

	assign res_push  = valid_s2 && !res_full;
	assign done      = res_push && is_last;
	assign slot_free = !valid_s2 || done;
	assign job_pop   = !job_empty && (job.op == OP_WRITE || slot_free);
	assign load      = job_pop && (job.op != OP_WRITE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_s2   <= '0;
		end else if (load) begin
			valid_s2 <= 1'b1;
			idx_s2   <= '0;
		end else if (done) begin
			valid_s2 <= 1'b0;
		end else if (res_push) begin
			idx_s2 <= idx_s2 + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_s2 <= job;
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop && job.op == OP_WRITE) begin
			table_q[job.addr] <= job.wdata;
		end
		if (load) begin
			rd_s2 <= table_q[job.addr];
		end
	end

endmodule
